@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the crossing test unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked implication check, disabled while reset is asserted.
`define CSCU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true while out of reset.
`define CSCU_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define CSCU_ASSERT(lbl, clk, rst_n, prop, msg)
`define CSCU_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ rtl/cscu_pkg.sv @@
// ----------------------------------------------------------------------------
// cscu_pkg
// Shared types and register codes of the circle segment crossing test unit.
// ----------------------------------------------------------------------------
package cscu_pkg;

  localparam int unsigned ADDR_BITS = 4;
  localparam int unsigned DATA_BITS = 32;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2
  } cscu_reg_e;

  typedef struct packed {
    logic enable;
    logic valid;
  } stage_ctrl_t;

endpackage

@@ rtl/cscu_delta.sv @@
// ----------------------------------------------------------------------------
// cscu_delta
// First pipeline stage: segment direction and endpoint-to-center offsets.
// ----------------------------------------------------------------------------
module cscu_delta #(
  parameter int unsigned COORD_BITS = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cscu_pkg::stage_ctrl_t        ctrl_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  output logic                         valid_o,
  output logic signed [COORD_BITS:0]   abx_o,
  output logic signed [COORD_BITS:0]   aby_o,
  output logic signed [COORD_BITS:0]   acx_o,
  output logic signed [COORD_BITS:0]   acy_o,
  output logic signed [COORD_BITS:0]   bcx_o,
  output logic signed [COORD_BITS:0]   bcy_o
);
  import cscu_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;

  logic              valid_q;
  logic signed [DW-1:0] abx_d, aby_d, acx_d, acy_d, bcx_d, bcy_d;
  logic signed [DW-1:0] abx_q, aby_q, acx_q, acy_q, bcx_q, bcy_q;

  assign abx_d = DW'(end_x_i) - DW'(start_x_i);
  assign aby_d = DW'(end_y_i) - DW'(start_y_i);
  assign acx_d = DW'(center_x_i) - DW'(start_x_i);
  assign acy_d = DW'(center_y_i) - DW'(start_y_i);
  assign bcx_d = DW'(center_x_i) - DW'(end_x_i);
  assign bcy_d = DW'(center_y_i) - DW'(end_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.enable) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.enable) begin
      abx_q <= abx_d;
      aby_q <= aby_d;
      acx_q <= acx_d;
      acy_q <= acy_d;
      bcx_q <= bcx_d;
      bcy_q <= bcy_d;
    end
  end

  assign valid_o = valid_q;
  assign abx_o   = abx_q;
  assign aby_o   = aby_q;
  assign acx_o   = acx_q;
  assign acy_o   = acy_q;
  assign bcx_o   = bcx_q;
  assign bcy_o   = bcy_q;

endmodule

@@ rtl/cscu_product.sv @@
// ----------------------------------------------------------------------------
// cscu_product
// Second pipeline stage: the cross, square and dot products and the squared radius.
// ----------------------------------------------------------------------------
module cscu_product #(
  parameter int unsigned COORD_BITS = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cscu_pkg::stage_ctrl_t            ctrl_i,
  input  logic signed [COORD_BITS:0]       abx_i,
  input  logic signed [COORD_BITS:0]       aby_i,
  input  logic signed [COORD_BITS:0]       acx_i,
  input  logic signed [COORD_BITS:0]       acy_i,
  input  logic signed [COORD_BITS:0]       bcx_i,
  input  logic signed [COORD_BITS:0]       bcy_i,
  input  logic        [COORD_BITS-2:0]     radius_i,
  output logic                             valid_o,
  output logic signed [2*COORD_BITS+1:0]   cr1_o,
  output logic signed [2*COORD_BITS+1:0]   cr2_o,
  output logic signed [2*COORD_BITS+1:0]   sq_abx_o,
  output logic signed [2*COORD_BITS+1:0]   sq_aby_o,
  output logic signed [2*COORD_BITS+1:0]   sq_acx_o,
  output logic signed [2*COORD_BITS+1:0]   sq_acy_o,
  output logic signed [2*COORD_BITS+1:0]   sq_bcx_o,
  output logic signed [2*COORD_BITS+1:0]   sq_bcy_o,
  output logic signed [2*COORD_BITS+1:0]   dot1a_o,
  output logic signed [2*COORD_BITS+1:0]   dot1b_o,
  output logic signed [2*COORD_BITS+1:0]   dot2a_o,
  output logic signed [2*COORD_BITS+1:0]   dot2b_o,
  output logic        [2*COORD_BITS-3:0]   r2_o
);
  import cscu_pkg::*;

  localparam int unsigned PW  = 2 * (COORD_BITS + 1);
  localparam int unsigned R2W = 2 * (COORD_BITS - 1);

  logic                 valid_q;
  logic signed [PW-1:0] abx_w, aby_w, acx_w, acy_w, bcx_w, bcy_w;
  logic signed [PW-1:0] cr1_q, cr2_q;
  logic signed [PW-1:0] sq_abx_q, sq_aby_q, sq_acx_q, sq_acy_q, sq_bcx_q, sq_bcy_q;
  logic signed [PW-1:0] dot1a_q, dot1b_q, dot2a_q, dot2b_q;
  logic [R2W-1:0]       r_w;
  logic [R2W-1:0]       r2_q;

  assign abx_w = PW'(abx_i);
  assign aby_w = PW'(aby_i);
  assign acx_w = PW'(acx_i);
  assign acy_w = PW'(acy_i);
  assign bcx_w = PW'(bcx_i);
  assign bcy_w = PW'(bcy_i);
  assign r_w   = R2W'(radius_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.enable) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.enable) begin
      cr1_q    <= abx_w * acy_w;
      cr2_q    <= aby_w * acx_w;
      sq_abx_q <= abx_w * abx_w;
      sq_aby_q <= aby_w * aby_w;
      sq_acx_q <= acx_w * acx_w;
      sq_acy_q <= acy_w * acy_w;
      sq_bcx_q <= bcx_w * bcx_w;
      sq_bcy_q <= bcy_w * bcy_w;
      dot1a_q  <= abx_w * acx_w;
      dot1b_q  <= aby_w * acy_w;
      dot2a_q  <= abx_w * bcx_w;
      dot2b_q  <= aby_w * bcy_w;
      r2_q     <= r_w * r_w;
    end
  end

  assign valid_o  = valid_q;
  assign cr1_o    = cr1_q;
  assign cr2_o    = cr2_q;
  assign sq_abx_o = sq_abx_q;
  assign sq_aby_o = sq_aby_q;
  assign sq_acx_o = sq_acx_q;
  assign sq_acy_o = sq_acy_q;
  assign sq_bcx_o = sq_bcx_q;
  assign sq_bcy_o = sq_bcy_q;
  assign dot1a_o  = dot1a_q;
  assign dot1b_o  = dot1b_q;
  assign dot2a_o  = dot2a_q;
  assign dot2b_o  = dot2b_q;
  assign r2_o     = r2_q;

endmodule

@@ rtl/cscu_reduce.sv @@
// ----------------------------------------------------------------------------
// cscu_reduce
// Third pipeline stage: cross product magnitude, squared lengths, endpoint
// containment and projection tests.
// ----------------------------------------------------------------------------
module cscu_reduce #(
  parameter int unsigned COORD_BITS = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cscu_pkg::stage_ctrl_t            ctrl_i,
  input  logic signed [2*COORD_BITS+1:0]   cr1_i,
  input  logic signed [2*COORD_BITS+1:0]   cr2_i,
  input  logic signed [2*COORD_BITS+1:0]   sq_abx_i,
  input  logic signed [2*COORD_BITS+1:0]   sq_aby_i,
  input  logic signed [2*COORD_BITS+1:0]   sq_acx_i,
  input  logic signed [2*COORD_BITS+1:0]   sq_acy_i,
  input  logic signed [2*COORD_BITS+1:0]   sq_bcx_i,
  input  logic signed [2*COORD_BITS+1:0]   sq_bcy_i,
  input  logic signed [2*COORD_BITS+1:0]   dot1a_i,
  input  logic signed [2*COORD_BITS+1:0]   dot1b_i,
  input  logic signed [2*COORD_BITS+1:0]   dot2a_i,
  input  logic signed [2*COORD_BITS+1:0]   dot2b_i,
  input  logic        [2*COORD_BITS-3:0]   r2_i,
  output logic                             valid_o,
  output logic        [2*COORD_BITS+1:0]   cross_abs_o,
  output logic        [2*COORD_BITS+1:0]   ab2_o,
  output logic        [2*COORD_BITS-3:0]   r2_o,
  output logic                             reach_o
);
  import cscu_pkg::*;

  localparam int unsigned PW  = 2 * (COORD_BITS + 1);
  localparam int unsigned R2W = 2 * (COORD_BITS - 1);

  logic                 valid_q;
  logic signed [PW-1:0] cross_d, dot1_d, dot2_d;
  logic [PW-1:0]        cross_abs_d, ab2_d, da2_d, db2_d, r2_w;
  logic                 reach_d;
  logic [PW-1:0]        cross_abs_q, ab2_q;
  logic [R2W-1:0]       r2_q;
  logic                 reach_q;

  // The magnitudes here always fit the product width, so no sum needs a carry bit.
  assign cross_d     = cr1_i - cr2_i;
  assign cross_abs_d = cross_d[PW-1] ? $unsigned(-cross_d) : $unsigned(cross_d);
  assign ab2_d       = $unsigned(sq_abx_i) + $unsigned(sq_aby_i);
  assign da2_d       = $unsigned(sq_acx_i) + $unsigned(sq_acy_i);
  assign db2_d       = $unsigned(sq_bcx_i) + $unsigned(sq_bcy_i);
  assign dot1_d      = dot1a_i + dot1b_i;
  assign dot2_d      = -dot2a_i - dot2b_i;
  assign r2_w        = PW'(r2_i);
  assign reach_d     = (da2_d <= r2_w) || (db2_d <= r2_w) ||
                       (!dot1_d[PW-1] && !dot2_d[PW-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.enable) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.enable) begin
      cross_abs_q <= cross_abs_d;
      ab2_q       <= ab2_d;
      r2_q        <= r2_i;
      reach_q     <= reach_d;
    end
  end

  assign valid_o     = valid_q;
  assign cross_abs_o = cross_abs_q;
  assign ab2_o       = ab2_q;
  assign r2_o        = r2_q;
  assign reach_o     = reach_q;

endmodule

@@ rtl/cscu_wide.sv @@
// ----------------------------------------------------------------------------
// cscu_wide
// Fourth pipeline stage: the two wide products of the line distance test.
// ----------------------------------------------------------------------------
module cscu_wide #(
  parameter int unsigned COORD_BITS = 14
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cscu_pkg::stage_ctrl_t          ctrl_i,
  input  logic [2*COORD_BITS+1:0]        cross_abs_i,
  input  logic [2*COORD_BITS+1:0]        ab2_i,
  input  logic [2*COORD_BITS-3:0]        r2_i,
  input  logic                           reach_i,
  output logic                           valid_o,
  output logic [4*COORD_BITS+3:0]        lhs_o,
  output logic [4*COORD_BITS-1:0]        rhs_o,
  output logic                           reach_o
);
  import cscu_pkg::*;

  localparam int unsigned PW  = 2 * (COORD_BITS + 1);
  localparam int unsigned R2W = 2 * (COORD_BITS - 1);
  localparam int unsigned LW  = 2 * PW;
  localparam int unsigned RW  = R2W + PW;

  logic          valid_q;
  logic [LW-1:0] lhs_q;
  logic [RW-1:0] rhs_q;
  logic          reach_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.enable) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.enable) begin
      lhs_q   <= LW'(cross_abs_i) * LW'(cross_abs_i);
      rhs_q   <= RW'(r2_i) * RW'(ab2_i);
      reach_q <= reach_i;
    end
  end

  assign valid_o = valid_q;
  assign lhs_o   = lhs_q;
  assign rhs_o   = rhs_q;
  assign reach_o = reach_q;

endmodule

@@ rtl/circle_segment_crossing_test_unit.sv @@
// ----------------------------------------------------------------------------
// circle_segment_crossing_test_unit
// Tests one segment per request against a configured circle and returns one
// crossing flag per request.
//
//   Channel   Direction  Handshake                 Payload
//   in        request    in_valid_i / in_stall_o   start_x_i start_y_i end_x_i end_y_i
//   out       result     out_valid_o / out_stall_i crossing_o
//   config    APB        psel penable pwrite pready paddr pwdata prdata
//
// A result is shown after its request is accepted and has passed the offset,
// product, sum and wide product stages and the output register.
// One request can be accepted every cycle, as every stage loads each cycle
// while the output is not stalled.
// Reset clears every stage valid bit and the circle registers to zero.
// A stall on the output halts only the stages that are full, so bubbles
// close up and in_stall_o rises once every stage and the output register hold a request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module circle_segment_crossing_test_unit #(
  parameter int unsigned COORD_BITS = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [COORD_BITS-1:0]        start_x_i,
  input  logic signed [COORD_BITS-1:0]        start_y_i,
  input  logic signed [COORD_BITS-1:0]        end_x_i,
  input  logic signed [COORD_BITS-1:0]        end_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                crossing_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cscu_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [cscu_pkg::DATA_BITS-1:0]      pwdata,
  output logic [cscu_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready
);
  import cscu_pkg::*;

  localparam int unsigned DW  = COORD_BITS + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned R2W = 2 * (COORD_BITS - 1);
  localparam int unsigned LW  = 2 * PW;
  localparam int unsigned RW  = R2W + PW;

  logic signed [COORD_BITS-1:0] center_x_q, center_y_q;
  logic [COORD_BITS-2:0]        radius_q;
  logic                         cfg_write;
  cscu_reg_e                    reg_sel;

  stage_ctrl_t s1_ctrl, s2_ctrl, s3_ctrl, s4_ctrl;
  logic        s1_valid, s2_valid, s3_valid, s4_valid;
  logic        s1_ready, s2_ready, s3_ready, s4_ready, out_ready;

  logic signed [DW-1:0] abx, aby, acx, acy, bcx, bcy;
  logic signed [PW-1:0] cr1, cr2, sq_abx, sq_aby, sq_acx, sq_acy, sq_bcx, sq_bcy;
  logic signed [PW-1:0] dot1a, dot1b, dot2a, dot2b;
  logic [R2W-1:0]       r2_s2, r2_s3;
  logic [PW-1:0]        cross_abs, ab2;
  logic                 reach_s3, reach_s4;
  logic [LW-1:0]        lhs;
  logic [RW-1:0]        rhs;

  logic out_valid_q;
  logic crossing_d, crossing_q;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = cscu_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_CENTER_X: center_x_q <= pwdata[COORD_BITS-1:0];
        REG_CENTER_Y: center_y_q <= pwdata[COORD_BITS-1:0];
        REG_RADIUS:   radius_q   <= pwdata[COORD_BITS-2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CENTER_X: prdata = DATA_BITS'($unsigned(center_x_q));
      REG_CENTER_Y: prdata = DATA_BITS'($unsigned(center_y_q));
      REG_RADIUS:   prdata = DATA_BITS'(radius_q);
      default:      prdata = '0;
    endcase
  end

  // Pipeline flow control: a stage loads when it is empty or its successor loads.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s4_ready   = !s4_valid || out_ready;
  assign s3_ready   = !s3_valid || s4_ready;
  assign s2_ready   = !s2_valid || s3_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign in_stall_o = !s1_ready;

  assign s1_ctrl = '{enable: s1_ready, valid: in_valid_i};
  assign s2_ctrl = '{enable: s2_ready, valid: s1_valid};
  assign s3_ctrl = '{enable: s3_ready, valid: s2_valid};
  assign s4_ctrl = '{enable: s4_ready, valid: s3_valid};

  cscu_delta #(.COORD_BITS(COORD_BITS)) u_delta (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (s1_ctrl),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .valid_o    (s1_valid),
    .abx_o      (abx),
    .aby_o      (aby),
    .acx_o      (acx),
    .acy_o      (acy),
    .bcx_o      (bcx),
    .bcy_o      (bcy)
  );

  cscu_product #(.COORD_BITS(COORD_BITS)) u_product (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (s2_ctrl),
    .abx_i    (abx),
    .aby_i    (aby),
    .acx_i    (acx),
    .acy_i    (acy),
    .bcx_i    (bcx),
    .bcy_i    (bcy),
    .radius_i (radius_q),
    .valid_o  (s2_valid),
    .cr1_o    (cr1),
    .cr2_o    (cr2),
    .sq_abx_o (sq_abx),
    .sq_aby_o (sq_aby),
    .sq_acx_o (sq_acx),
    .sq_acy_o (sq_acy),
    .sq_bcx_o (sq_bcx),
    .sq_bcy_o (sq_bcy),
    .dot1a_o  (dot1a),
    .dot1b_o  (dot1b),
    .dot2a_o  (dot2a),
    .dot2b_o  (dot2b),
    .r2_o     (r2_s2)
  );

  cscu_reduce #(.COORD_BITS(COORD_BITS)) u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (s3_ctrl),
    .cr1_i       (cr1),
    .cr2_i       (cr2),
    .sq_abx_i    (sq_abx),
    .sq_aby_i    (sq_aby),
    .sq_acx_i    (sq_acx),
    .sq_acy_i    (sq_acy),
    .sq_bcx_i    (sq_bcx),
    .sq_bcy_i    (sq_bcy),
    .dot1a_i     (dot1a),
    .dot1b_i     (dot1b),
    .dot2a_i     (dot2a),
    .dot2b_i     (dot2b),
    .r2_i        (r2_s2),
    .valid_o     (s3_valid),
    .cross_abs_o (cross_abs),
    .ab2_o       (ab2),
    .r2_o        (r2_s3),
    .reach_o     (reach_s3)
  );

  cscu_wide #(.COORD_BITS(COORD_BITS)) u_wide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (s4_ctrl),
    .cross_abs_i (cross_abs),
    .ab2_i       (ab2),
    .r2_i        (r2_s3),
    .reach_i     (reach_s3),
    .valid_o     (s4_valid),
    .lhs_o       (lhs),
    .rhs_o       (rhs),
    .reach_o     (reach_s4)
  );

  // The line passes strictly inside the circle and the segment reaches it.
  assign crossing_d = (lhs < LW'(rhs)) && reach_s4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s4_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      crossing_q <= crossing_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign crossing_o  = crossing_q;

  `CSCU_ASSERT(a_stall_only_when_full, clk_i, rst_ni, in_stall_o |-> (s1_valid && s2_valid && s3_valid && s4_valid && out_valid_q), "input stalled while a stage is empty")
  `CSCU_ASSERT(a_accept_fills_s1, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> s1_valid, "accepted request did not reach the first stage")
  `CSCU_ASSERT(a_s4_moves_out, clk_i, rst_ni, (s4_valid && out_ready) |=> out_valid_o, "last stage request was lost on its way out")
  `CSCU_NEVER(a_out_stall_holds, clk_i, rst_ni, (s4_valid && !out_ready && s4_ready), "inconsistent ready chain at last stage")

endmodule

@@ sim/circle_segment_crossing_test_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_segment_crossing_test_unit_tb
// Streams segment requests through the crossing test unit under several circle
// settings and random idle and stall patterns. A scoreboard predicts the
// crossing flag of every accepted request and compares it with each result.
// ----------------------------------------------------------------------------
module circle_segment_crossing_test_unit_tb;
  import cscu_pkg::*;

  localparam int unsigned COORD_BITS = 14;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned LONG_HOLD = 80;
  localparam int unsigned PHASE_ITEMS = 190;
  localparam logic [1:0] UNMAPPED_REG = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-2:0] radius_t;

  class crossing_scoreboard;
    coord_t center_x;
    coord_t center_y;
    logic [COORD_BITS-2:0] radius;
    bit expected_crossings[$];
    int unsigned failures;

    function new();
      center_x = '0;
      center_y = '0;
      radius = '0;
      failures = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [DATA_BITS-1:0] data);
      case (index)
        REG_CENTER_X: center_x = data[COORD_BITS-1:0];
        REG_CENTER_Y: center_y = data[COORD_BITS-1:0];
        REG_RADIUS: radius = data[COORD_BITS-2:0];
        default: ;
      endcase
    endfunction

    function bit predict_crossing(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      longint ax, ay, bx, by, cx, cy, r2;
      longint abx, aby, acx, acy, bcx, bcy;
      longint cr, ab2, d1, d2, ds, de;
      bit hit;
      ax = sx;
      ay = sy;
      bx = ex;
      by = ey;
      cx = center_x;
      cy = center_y;
      r2 = longint'(radius) * longint'(radius);
      abx = bx - ax;
      aby = by - ay;
      acx = cx - ax;
      acy = cy - ay;
      bcx = cx - bx;
      bcy = cy - by;
      cr = abx * acy - aby * acx;
      if (cr < 0) begin
        cr = -cr;
      end
      ab2 = abx * abx + aby * aby;
      hit = 1'b0;
      if (cr * cr < r2 * ab2) begin
        ds = acx * acx + acy * acy;
        de = bcx * bcx + bcy * bcy;
        if (ds <= r2 || de <= r2) begin
          hit = 1'b1;
        end else begin
          d1 = abx * acx + aby * acy;
          d2 = -(abx * bcx) - aby * bcy;
          hit = (d1 >= 0) && (d2 >= 0);
        end
      end
      return hit;
    endfunction

    function void note_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      expected_crossings.push_back(predict_crossing(sx, sy, ex, ey));
    endfunction

    function void check_crossing(logic crossing);
      bit want;
      if (expected_crossings.size() == 0) begin
        $error("crossing result %0d arrived with no request pending", crossing);
        failures++;
      end else begin
        want = expected_crossings.pop_front();
        if (crossing !== want) begin
          $error("crossing mismatch: expected %0d, actual %0d", want, crossing);
          failures++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_crossings.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  coord_t start_x_i = '0;
  coord_t start_y_i = '0;
  coord_t end_x_i = '0;
  coord_t end_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic crossing_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic pready;

  crossing_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_done = 0;
  int unsigned quiet_cycles = 0;

  circle_segment_crossing_test_unit #(
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .start_x_i(start_x_i),
    .start_y_i(start_y_i),
    .end_x_i(end_x_i),
    .end_y_i(end_y_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .crossing_o(crossing_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_segment(start_x_i, start_y_i, end_x_i, end_y_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_crossing(crossing_o);
    end
  end

  // The receiver either stalls at random or, when asked, holds off for a
  // long stretch so that the pipeline fills and backs up into the request side.
  always @(posedge clk_i) begin
    if (hold_asked != hold_done) begin
      out_stall_i <= 1'b1;
      repeat (LONG_HOLD) @(posedge clk_i);
      hold_done++;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_write(logic [1:0] index, logic [DATA_BITS-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_register(index, data);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure_circle(coord_t cx, coord_t cy, logic [COORD_BITS-2:0] r);
    logic [DATA_BITS-1:0] data;
    data = $urandom;
    data[COORD_BITS-1:0] = cx;
    apb_write(REG_CENTER_X, data);
    data = $urandom;
    data[COORD_BITS-1:0] = cy;
    apb_write(REG_CENTER_Y, data);
    data = $urandom;
    data[COORD_BITS-2:0] = r;
    apb_write(REG_RADIUS, data);
  endtask

  task automatic send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_x_i <= sx;
    start_y_i <= sy;
    end_x_i <= ex;
    end_y_i <= ey;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic coord_t near_coord(coord_t c, int unsigned span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - int'(span);
    return v[COORD_BITS-1:0];
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(4))
      0: return coord_t'(-8192);
      1: return coord_t'(8191);
      2: return coord_t'(0);
      3: return coord_t'(-1);
      default: return coord_t'(1);
    endcase
  endfunction

  task automatic send_random_segment();
    int unsigned kind;
    int unsigned span;
    coord_t sx, sy, ex, ey;
    kind = $urandom_range(99);
    span = 2 * int'(sb.radius) + 16;
    if (kind < 15) begin
      sx = coord_t'($urandom);
      sy = coord_t'($urandom);
      ex = coord_t'($urandom);
      ey = coord_t'($urandom);
    end else if (kind < 22) begin
      sx = extreme_coord();
      sy = extreme_coord();
      ex = extreme_coord();
      ey = extreme_coord();
    end else if (kind < 28) begin
      sx = near_coord(sb.center_x, span);
      sy = near_coord(sb.center_y, span);
      ex = sx;
      ey = sy;
    end else begin
      sx = near_coord(sb.center_x, span);
      sy = near_coord(sb.center_y, span);
      ex = near_coord(sb.center_x, span);
      ey = near_coord(sb.center_y, span);
    end
    send_segment(sx, sy, ex, ey);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Circle registers come out of reset at zero, so nothing crosses yet.
    repeat (4) send_random_segment();
    wait_drained();

    configure_circle(0, 0, 100);
    send_segment(-8192, -8192, 8191, 8191);
    send_segment(8191, -8192, -8192, 8191);
    send_segment(-1, -1, 1, 1);
    send_segment(10, 10, 10, 10);
    send_segment(-200, 100, 200, 100);
    send_segment(0, 0, 500, 500);
    send_segment(-500, 50, 500, 50);
    send_segment(200, 50, 500, 50);
    send_segment(100, 0, 300, 50);
    send_segment(-8192, 8191, 8191, 8191);
    send_segment(-8192, -8192, -8192, -8192);
    send_segment(8191, 8191, 8191, 8191);
    send_segment(50, -300, 50, 300);
    send_segment(-300, -99, 300, -99);
    wait_drained();

    apb_write(UNMAPPED_REG, 32'hFFFF_FFFF);
    repeat (6) send_random_segment();
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: configure_circle(0, 0, 0);
        1: configure_circle(-8192, 8191, 8191);
        2: configure_circle(8191, -8192, 1);
        3: configure_circle(-8192, -8192, 8191);
        default: configure_circle(coord_t'($urandom), coord_t'($urandom),
                                  ($urandom_range(1) != 0)
                                    ? radius_t'($urandom_range(1, 300))
                                    : radius_t'($urandom_range(0, 8191)));
      endcase
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 56;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 56;
        end
        default: begin
          send_idle_pct = 35;
          stall_pct = 35;
        end
      endcase
      if (phase == 4) begin
        hold_asked++;
      end
      repeat (PHASE_ITEMS) send_random_segment();
      wait_drained();
    end

    stall_pct = 0;
    repeat (10) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/cscu_pkg.sv
rtl/cscu_delta.sv
rtl/cscu_product.sv
rtl/cscu_reduce.sv
rtl/cscu_wide.sv
rtl/circle_segment_crossing_test_unit.sv
sim/circle_segment_crossing_test_unit_tb.sv
